[hdl/lca_pkg.sv]
// ----------------------------------------------------------------------------
// lca_pkg: shared types and constants for the binary-lifting LCA block.
// Holds the operation codes of an input word.
// ----------------------------------------------------------------------------
package lca_pkg;

  localparam int FIELD_W = 11;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_BUILD = 2'd1,
    OP_ROOT  = 2'd2,
    OP_QUERY = 2'd3
  } op_t;

endpackage

[hdl/tree_lca_binary_lifting_reroot.sv]
// ----------------------------------------------------------------------------
// tree_lca_binary_lifting_reroot: lowest common ancestor by binary lifting
// with a movable root.
//
//   channel   dir  contents
//   s_axis    in   tdata: mode, node_a, node_b, node_depth
//   m_axis    out  tdata: ancestor
//   cfg       in   cfg_we/cfg_wdata: num_nodes
//
// Load and set-root words finish in the cycle that accepts them. A build
// fills levels 1 to LOG_LEVELS-1 for nodes 1 to min(num_nodes, MAX_NODES).
// Each LCA walk lifts the deeper node level by level, then climbs both
// nodes together; a plain query is one walk and a rerooted query is three
// walks plus a depth compare. Input is taken only while idle; a finished
// query waits in its last state while the output register still holds an
// untaken result.
// Reset is synchronous; tables are not cleared.
// ----------------------------------------------------------------------------
module tree_lca_binary_lifting_reroot
  import lca_pkg::*;
#(
  parameter int MAX_NODES  = 1024,
  parameter int LOG_LEVELS = 10
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [1:0] mode, [12:2] node_a, [23:13] node_b, [34:24] node_depth
  input  logic [39:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [10:0] ancestor
  output logic [15:0] m_axis_tdata,
  input  logic        cfg_we,
  input  logic [10:0] cfg_wdata
);

  localparam int LW   = (LOG_LEVELS > 1) ? $clog2(LOG_LEVELS) : 1;
  localparam int JD   = (MAX_NODES + 1) * LOG_LEVELS;
  localparam int JAW  = $clog2(JD);
  localparam int NDW  = $clog2(MAX_NODES + 1);

  typedef enum logic [16:0] {
    S_IDLE  = 17'h00001,
    S_BLD_R = 17'h00002,
    S_BLD_W = 17'h00004,
    S_BLD_X = 17'h00008,
    S_W_ST  = 17'h00010,
    S_W_DW  = 17'h00020,
    S_W_DD  = 17'h00040,
    S_UP_R  = 17'h00080,
    S_UP_D  = 17'h00100,
    S_UP_C  = 17'h00200,
    S_EQ    = 17'h00400,
    S_DN_R  = 17'h00800,
    S_DN_C  = 17'h01000,
    S_FIN_R = 17'h02000,
    S_FIN_C = 17'h04000,
    S_DEP   = 17'h08000,
    S_OUT   = 17'h10000
  } st_t;

  st_t st;

  logic [10:0] num_nodes, root;
  logic [10:0] qa, qb;
  logic [10:0] wu, wv;        // walk registers
  logic [10:0] dv;            // depth of the shallower walk node
  logic [LW-1:0] lvl;
  logic [1:0]  walk;          // which of the three walks
  logic [10:0] res [3];
  logic [10:0] rdep [2];
  logic [10:0] bk;            // build node
  logic [10:0] bmid;
  logic [10:0] ans;
  logic        ovalid;
  logic [1:0]  dcnt;

  // Memory ports.
  logic           j_we, d_we;
  logic [JAW-1:0] j_wa, j_ra0, j_ra1;
  logic [10:0]    j_wd, j_rd0, j_rd1;
  logic [NDW-1:0] d_wa, d_ra0, d_ra1;
  logic [10:0]    d_wd, d_rd0, d_rd1;

  lca_mem #(.DEPTH(JD), .WIDTH(11)) u_jump (
    .clk(clk), .we(j_we), .waddr(j_wa), .wdata(j_wd),
    .raddr0(j_ra0), .rdata0(j_rd0), .raddr1(j_ra1), .rdata1(j_rd1));

  lca_mem #(.DEPTH(MAX_NODES + 1), .WIDTH(11)) u_depth (
    .clk(clk), .we(d_we), .waddr(d_wa), .wdata(d_wd),
    .raddr0(d_ra0), .rdata0(d_rd0), .raddr1(d_ra1), .rdata1(d_rd1));

  function automatic logic [10:0] nix(input logic [10:0] x);
    return (x >= 11'd1 && 32'(x) <= MAX_NODES) ? x : 11'd0;
  endfunction

  function automatic logic [JAW-1:0] jaddr(input logic [10:0] n,
                                           input logic [LW-1:0] l);
    logic [31:0] a;
    a = 32'(nix(n)) * LOG_LEVELS + 32'(l);
    return a[JAW-1:0];
  endfunction

  wire [1:0]  in_mode  = s_axis_tdata[1:0];
  wire [10:0] in_a     = s_axis_tdata[12:2];
  wire [10:0] in_b     = s_axis_tdata[23:13];
  wire [10:0] in_d     = s_axis_tdata[34:24];
  wire        acc      = s_axis_tvalid && s_axis_tready;
  wire [10:0] last_nd  = (32'(num_nodes) > MAX_NODES) ? 11'(MAX_NODES) : num_nodes;
  wire [31:0] dv_step  = 32'(dv) + (32'd1 << lvl);
  wire [10:0] wu_dep   = (wu == 11'd0) ? 11'd0 : d_rd0;
  wire [10:0] zero_fix_u = nix(wu);
  wire [10:0] zero_fix_v = nix(wv);
  // The output register can take a new word when empty or being drained.
  wire        out_free = !ovalid || m_axis_tready;
  wire        fin_now  = out_free &&
                         ((st == S_DEP && walk == 2'd2 && root == 11'd1) ||
                          (st == S_OUT && dcnt == 2'd3));

  assign s_axis_tready = (st == S_IDLE);
  assign m_axis_tvalid = ovalid;
  assign m_axis_tdata  = {5'd0, ans};

  // Memory addressing follows the state.
  always_comb begin
    j_we = 1'b0; j_wa = '0; j_wd = '0;
    d_we = 1'b0; d_wa = '0; d_wd = in_d;
    j_ra0 = jaddr(wu, lvl);
    j_ra1 = jaddr(wv, lvl);
    d_ra0 = NDW'(zero_fix_u);
    d_ra1 = NDW'(zero_fix_v);
    if (st == S_IDLE && acc && in_mode == OP_LOAD && nix(in_a) != 11'd0) begin
      j_we = 1'b1; j_wa = jaddr(in_a, '0); j_wd = nix(in_b);
      d_we = 1'b1; d_wa = NDW'(nix(in_a));
    end
    if (st == S_BLD_R) begin
      j_ra0 = jaddr(bk, LW'(lvl - LW'(1)));
    end
    if (st == S_BLD_W) begin
      j_ra0 = jaddr(j_rd0, LW'(lvl - LW'(1)));
    end
    if (st == S_BLD_X) begin
      j_we = 1'b1; j_wa = jaddr(bk, lvl); j_wd = (bmid == 11'd0) ? 11'd0 : j_rd0;
    end
    if (st == S_FIN_R) begin
      j_ra0 = jaddr(wu, '0);
    end
    if (st == S_DEP) begin
      d_ra0 = NDW'(nix(res[0]));
      d_ra1 = NDW'(nix(res[1]));
    end
  end

  // Sequencer: load, build, set root and the LCA walks.
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_IDLE; ovalid <= 1'b0; num_nodes <= 11'd1; root <= 11'd1;
    end else begin
      if (cfg_we) num_nodes <= cfg_wdata;
      if (ovalid && m_axis_tready && !fin_now) ovalid <= 1'b0;
      case (st)
        S_IDLE: if (acc) begin
          qa <= in_a; qb <= in_b;
          if (in_mode == OP_ROOT) begin
            root <= in_a;
          end else if (in_mode == OP_BUILD) begin
            if (LOG_LEVELS > 1 && last_nd != 11'd0) begin
              bk <= 11'd1; lvl <= LW'(1); st <= S_BLD_R;
            end
          end else if (in_mode == OP_QUERY) begin
            walk <= (root == 11'd1) ? 2'd2 : 2'd0;
            wu <= (root == 11'd1) ? in_a : in_a;
            wv <= (root == 11'd1) ? in_b : root;
            st <= S_W_ST;
          end
        end
        S_BLD_R: st <= S_BLD_W;
        S_BLD_W: begin bmid <= nix(j_rd0); st <= S_BLD_X; end
        S_BLD_X: begin
          if (bk == last_nd) begin
            bk <= 11'd1;
            if (32'(lvl) == LOG_LEVELS - 1) st <= S_IDLE;
            else begin lvl <= LW'(lvl + LW'(1)); st <= S_BLD_R; end
          end else begin
            bk <= 11'(bk + 11'd1); st <= S_BLD_R;
          end
        end
        // Read both depths, then order so that wu is the deeper node.
        S_W_ST: begin wu <= nix(wu); wv <= nix(wv); st <= S_W_DW; end
        S_W_DW: st <= S_W_DD;
        S_W_DD: begin
          logic [10:0] a0, b0;
          a0 = (wu == 11'd0) ? 11'd0 : d_rd0;
          b0 = (wv == 11'd0) ? 11'd0 : d_rd1;
          if (a0 < b0) begin
            wu <= wv; wv <= wu; dv <= a0;
          end else begin
            dv <= b0;
          end
          lvl <= LW'(LOG_LEVELS - 1); st <= S_UP_R;
        end
        // Lift wu; its depth is read back from the table at every level.
        S_UP_R: st <= S_UP_D;
        S_UP_D: begin
          if (32'(wu_dep) >= dv_step) begin
            wu <= (wu == 11'd0) ? 11'd0 : j_rd0;
          end
          st <= S_UP_C;
        end
        S_UP_C: begin
          if (lvl == '0) st <= S_EQ;
          else begin lvl <= LW'(lvl - LW'(1)); st <= S_UP_R; end
        end
        S_EQ: begin
          if (wu == wv) begin
            res[walk] <= wu; st <= S_DEP;
          end else begin
            lvl <= LW'(LOG_LEVELS - 1); st <= S_DN_R;
          end
        end
        S_DN_R: st <= S_DN_C;
        S_DN_C: begin
          logic [10:0] ju, jv;
          ju = (wu == 11'd0) ? 11'd0 : j_rd0;
          jv = (wv == 11'd0) ? 11'd0 : j_rd1;
          if (ju != jv) begin wu <= ju; wv <= jv; end
          if (lvl == '0) st <= S_FIN_R;
          else begin lvl <= LW'(lvl - LW'(1)); st <= S_DN_R; end
        end
        S_FIN_R: st <= S_FIN_C;
        S_FIN_C: begin
          res[walk] <= (wu == 11'd0) ? 11'd0 : j_rd0; st <= S_DEP;
        end
        // After a walk: start the next one or pick the deepest answer.
        S_DEP: begin
          if (walk == 2'd0) begin
            walk <= 2'd1; wu <= qb; wv <= root; st <= S_W_ST; dcnt <= 2'd0;
          end else if (walk == 2'd1) begin
            walk <= 2'd2; wu <= qa; wv <= qb; st <= S_W_ST; dcnt <= 2'd0;
          end else if (root == 11'd1) begin
            if (out_free) begin
              ans <= res[2]; ovalid <= 1'b1; st <= S_IDLE;
            end
          end else begin
            dcnt <= 2'(dcnt + 2'd1);
            if (dcnt == 2'd1) begin
              rdep[0] <= (nix(res[0]) == 11'd0) ? 11'd0 : d_rd0;
              rdep[1] <= (nix(res[1]) == 11'd0) ? 11'd0 : d_rd1;
              wu <= res[2]; wv <= res[2];
              st <= S_OUT;
            end
          end
        end
        S_OUT: begin
          // depth of lca(u,v) read through port 0 using wu
          logic [10:0] d2;
          d2 = (nix(res[2]) == 11'd0) ? 11'd0 : d_rd0;
          if (dcnt != 2'd3) begin
            dcnt <= 2'(dcnt + 2'd1);
          end else if (out_free) begin
            if (rdep[0] >= rdep[1] && rdep[0] >= d2) ans <= res[0];
            else if (rdep[1] >= rdep[0] && rdep[1] >= d2) ans <= res[1];
            else ans <= res[2];
            ovalid <= 1'b1; st <= S_IDLE;
          end
        end
        default: st <= S_IDLE;
      endcase
    end
  end

  // A result never appears while a word is still being worked on.
  assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(st == S_DEP || st == S_OUT))
    else $error("result raised outside the final states");
  // A waiting result stays offered until it is taken.
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("pending result dropped");
  // A held result does not change.
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result changed while stalled");

endmodule

[hdl/lca_mem.sv]
// ----------------------------------------------------------------------------
// lca_mem: generic single-write, dual-read synchronous memory.
// Read data is registered and appears in the cycle after the address.
// ----------------------------------------------------------------------------
module lca_mem #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 11
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr0,
  output logic [WIDTH-1:0]         rdata0,
  input  logic [$clog2(DEPTH)-1:0] raddr1,
  output logic [WIDTH-1:0]         rdata1
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and two registered read ports.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata0 <= mem[raddr0];
    rdata1 <= mem[raddr1];
  end

endmodule

[tb/lca_checker.sv]
// ----------------------------------------------------------------------------
// lca_checker: scoreboard for the binary-lifting LCA block.
// Mirrors the ancestor and depth tables from the accepted input words and
// configuration writes, predicts the answer of each query, and compares it
// with every word that leaves the block.
// ----------------------------------------------------------------------------
module lca_checker
  import lca_pkg::*;
#(
  parameter int MAX_NODES  = 1024,
  parameter int LOG_LEVELS = 10
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [15:0] m_axis_tdata,
  input  logic        cfg_we,
  input  logic [10:0] cfg_wdata,
  output int          fail_count,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [10:0] anc_tbl [0:MAX_NODES][0:LOG_LEVELS-1];
  logic [10:0] dep_tbl [0:MAX_NODES];
  logic [10:0] root_node;
  logic [10:0] node_count;
  logic [10:0] answer_q [$];
  int          mismatches;

  assign fail_count = mismatches;
  assign pending    = answer_q.size();

  // The mirror starts from all zero; row zero stands for "none" forever.
  initial begin
    mismatches = 0;
    for (int n = 0; n <= MAX_NODES; n++) begin
      dep_tbl[n] = '0;
      for (int j = 0; j < LOG_LEVELS; j++) anc_tbl[n][j] = '0;
    end
  end

  function automatic logic [10:0] clip_node(logic [10:0] x);
    return (x >= 1 && x <= MAX_NODES) ? x : 11'd0;
  endfunction

  // Plain lowest common ancestor by lifting the deeper node first.
  function automatic logic [10:0] meet(logic [10:0] a, logic [10:0] b);
    logic [10:0] u, v, t;
    u = clip_node(a);
    v = clip_node(b);
    if (dep_tbl[u] < dep_tbl[v]) begin
      t = u; u = v; v = t;
    end
    for (int i = LOG_LEVELS - 1; i >= 0; i--) begin
      if (int'(dep_tbl[u]) >= int'(dep_tbl[v]) + (1 << i)) u = anc_tbl[u][i];
    end
    if (u == v) return u;
    for (int i = LOG_LEVELS - 1; i >= 0; i--) begin
      if (anc_tbl[u][i] != anc_tbl[v][i]) begin
        u = anc_tbl[u][i];
        v = anc_tbl[v][i];
      end
    end
    return anc_tbl[u][0];
  endfunction

  // Under a moved root the deepest of the three meeting points wins,
  // the earlier one on a tie.
  function automatic logic [10:0] rooted_meet(logic [10:0] a, logic [10:0] b);
    logic [10:0] lu, lv, luv;
    if (root_node == 11'd1) return meet(a, b);
    lu  = meet(a, root_node);
    lv  = meet(b, root_node);
    luv = meet(a, b);
    if (dep_tbl[lu] >= dep_tbl[lv] && dep_tbl[lu] >= dep_tbl[luv]) return lu;
    if (dep_tbl[lv] >= dep_tbl[lu] && dep_tbl[lv] >= dep_tbl[luv]) return lv;
    return luv;
  endfunction

  task automatic apply_word(logic [39:0] w);
    op_t         op;
    logic [10:0] na, nb, nd, n;
    int          last;
    op = op_t'(w[1:0]);
    na = w[12:2];
    nb = w[23:13];
    nd = w[34:24];
    case (op)
      OP_LOAD: begin
        n = clip_node(na);
        if (n != 0) begin
          anc_tbl[n][0] = clip_node(nb);
          dep_tbl[n]    = nd;
        end
      end
      OP_BUILD: begin
        last = (node_count > MAX_NODES) ? MAX_NODES : int'(node_count);
        for (int j = 1; j < LOG_LEVELS; j++)
          for (int k = 1; k <= last; k++)
            anc_tbl[k][j] = anc_tbl[anc_tbl[k][j-1]][j-1];
      end
      OP_ROOT: root_node = na;
      default: answer_q = {answer_q, rooted_meet(na, nb)};
    endcase
  endtask

  // Watch all three channels on every rising edge.
  always @(posedge clk) begin
    logic [10:0] want;
    if (rst) begin
      root_node  = 11'd1;
      node_count = 11'd1;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (answer_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected result word, ancestor %0d", $realtime,
                     m_axis_tdata[10:0]);
        end else begin
          want = answer_q.pop_front();
          if (m_axis_tdata[10:0] !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: ancestor mismatch, expected %0d, got %0d", $realtime,
                       want, m_axis_tdata[10:0]);
          end
        end
      end
      if (cfg_we) node_count = cfg_wdata;
      if (s_axis_tvalid && s_axis_tready) apply_word(s_axis_tdata);
    end
  end

endmodule

[tb/tree_lca_binary_lifting_reroot_tb.sv]
// ----------------------------------------------------------------------------
// tree_lca_binary_lifting_reroot_tb: stimulus and verdict for the LCA block.
// Loads random trees, builds the ancestor table under several node counts,
// and sends queries under moving roots with bursty input and a stalling
// output; the checker module predicts and compares every answer.
// ----------------------------------------------------------------------------
module tree_lca_binary_lifting_reroot_tb;
  import lca_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAXN = 1024;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic        cfg_we = 1'b0;
  logic [10:0] cfg_wdata = '0;
  int          fail_count;
  int          pending;

  logic        hold_req = 1'b0;
  logic        hold_out = 1'b0;
  int          burst_left = 0;
  int          out_mode = 0;
  int          out_cycle = 0;
  int          tree_depth [1:MAXN];

  always #4 clk = ~clk;

  tree_lca_binary_lifting_reroot uut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  lca_checker chk (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .fail_count(fail_count), .pending(pending)
  );

  // Receiver: switches between always ready, coin flip and mostly stalled.
  always @(posedge clk) begin
    out_cycle <= out_cycle + 1;
    if (out_cycle % 200 == 0) out_mode <= int'($urandom_range(0, 2));
    if (hold_out) m_axis_tready <= 1'b0;
    else if (out_mode == 0) m_axis_tready <= 1'b1;
    else if (out_mode == 1) m_axis_tready <= 1'($urandom_range(0, 1));
    else m_axis_tready <= ($urandom_range(0, 3) == 0);
  end

  // Long output stall once requested, so the block backs up its input.
  initial begin
    wait (hold_req);
    @(posedge clk);
    hold_out <= 1'b1;
    repeat (3000) @(posedge clk);
    hold_out <= 1'b0;
  end

  initial begin
    #50ms;
    $display("tree_lca_binary_lifting_reroot_tb failed");
    $finish;
  end

  function automatic logic [39:0] pack_word(op_t op, logic [10:0] a, logic [10:0] b,
                                            logic [10:0] d);
    return {5'b0, d, b, a, op};
  endfunction

  // Send one word; bursts of random length separated by random gaps.
  task automatic send(logic [39:0] w);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 3) == 0 ? 0 : int'($urandom_range(1, 6));
      burst_left = int'($urandom_range(1, 12));
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= w;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  // Write the node count once every expected answer has come back.
  task automatic write_count(logic [10:0] v);
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Load nodes 1..n; style 0 random parents, 1 bushy chain, 2 straight chain.
  task automatic load_tree(int n, int style);
    int p;
    for (int k = 1; k <= n; k++) begin
      if (k == 1) p = 0;
      else if (style == 0) p = int'($urandom_range(1, k - 1));
      else if (style == 1) p = (k - 1 - int'($urandom_range(0, 2)) < 1) ? 1
                               : k - 1 - int'($urandom_range(0, 2));
      else p = k - 1;
      tree_depth[k] = (p == 0) ? 1 : tree_depth[p] + 1;
      send(pack_word(OP_LOAD, 11'(k), 11'(p), 11'(tree_depth[k])));
    end
  endtask

  function automatic logic [10:0] pick_node(int range_hi);
    int r;
    r = int'($urandom_range(0, 11));
    if (r == 0) return 11'd0;
    if (r == 1) return 11'($urandom_range(MAXN + 1, 2047));
    return 11'($urandom_range(1, range_hi));
  endfunction

  // Random words over nodes 1..range_hi; ends with a query.
  task automatic random_words(int range_hi, int count, bit allow_build);
    int done, r, k, p;
    done = 0;
    while (done < count) begin
      r = int'($urandom_range(0, 99));
      if (r < 60 || (r >= 83 && r < 90 && range_hi < 2) || (r >= 90 && r < 93 && !allow_build))
      begin
        send(pack_word(OP_QUERY, pick_node(range_hi), pick_node(range_hi),
                       11'($urandom_range(0, 2047))));
        done++;
      end else if (r < 75) begin
        send(pack_word(OP_ROOT, $urandom_range(0, 1) ? 11'd1 : pick_node(range_hi),
                       11'($urandom_range(0, 2047)), 11'($urandom_range(0, 2047))));
        done++;
      end else if (r < 83) begin
        // Loads of a node that does not exist are dropped by the block.
        send(pack_word(OP_LOAD,
                       $urandom_range(0, 1) ? 11'd0 : 11'($urandom_range(MAXN + 1, 2047)),
                       11'($urandom_range(0, 2047)), 11'($urandom_range(0, 2047))));
      end else if (r < 90) begin
        k = int'($urandom_range(2, range_hi));
        p = int'($urandom_range(1, k - 1));
        tree_depth[k] = tree_depth[p] + 1;
        send(pack_word(OP_LOAD, 11'(k), 11'(p), 11'(tree_depth[k])));
        done++;
      end else if (r < 93) begin
        send(pack_word(OP_BUILD, 11'($urandom_range(0, 2047)), 11'($urandom_range(0, 2047)),
                       11'($urandom_range(0, 2047))));
        done++;
      end else begin
        // Odd depth and parent values: the tree goes inconsistent.
        k = int'($urandom_range(1, range_hi));
        tree_depth[k] = int'($urandom_range(1, 2047));
        send(pack_word(OP_LOAD, 11'(k), 11'($urandom_range(0, 2047)), 11'(tree_depth[k])));
        done++;
      end
    end
    send(pack_word(OP_QUERY, pick_node(range_hi), pick_node(range_hi), 11'd0));
  endtask

  initial begin
    int small_n;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Count above the table size: the build covers every node of a deep tree.
    write_count(11'd2047);
    load_tree(MAXN, 1);
    send(pack_word(OP_LOAD, 11'd0, 11'd5, 11'd3));
    send(pack_word(OP_LOAD, 11'd1025, 11'd1, 11'd2));
    send(pack_word(OP_LOAD, 11'd2047, 11'd2047, 11'd2047));
    send(pack_word(OP_LOAD, 11'd1, 11'd2047, 11'd1));
    send(pack_word(OP_BUILD, 11'd0, 11'd0, 11'd0));

    // Directed queries: extremes, nodes out of range, moved roots.
    send(pack_word(OP_QUERY, 11'd1, 11'd1, 11'd0));
    send(pack_word(OP_QUERY, 11'd1024, 11'd1024, 11'd0));
    send(pack_word(OP_QUERY, 11'd1024, 11'd1023, 11'd2047));
    send(pack_word(OP_QUERY, 11'd0, 11'd5, 11'd0));
    send(pack_word(OP_QUERY, 11'd2047, 11'd3, 11'd0));
    send(pack_word(OP_QUERY, 11'd1025, 11'd1, 11'd0));
    send(pack_word(OP_ROOT, 11'd1024, 11'd0, 11'd0));
    send(pack_word(OP_QUERY, 11'd1, 11'd1024, 11'd0));
    send(pack_word(OP_QUERY, 11'd512, 11'd700, 11'd0));
    send(pack_word(OP_ROOT, 11'd0, 11'd0, 11'd0));
    send(pack_word(OP_QUERY, 11'd17, 11'd900, 11'd0));
    send(pack_word(OP_ROOT, 11'd2047, 11'd2047, 11'd2047));
    send(pack_word(OP_QUERY, 11'd2047, 11'd2047, 11'd0));
    send(pack_word(OP_ROOT, 11'd1, 11'd0, 11'd0));
    send(pack_word(OP_QUERY, 11'd300, 11'd301, 11'd0));

    // Random traffic with a long output stall.
    hold_req <= 1'b1;
    random_words(MAXN, 80, 1'b0);

    // A zero count builds nothing; a count of one builds the root only.
    write_count(11'd0);
    send(pack_word(OP_BUILD, 11'd0, 11'd0, 11'd0));
    random_words(MAXN, 40, 1'b1);
    write_count(11'd1);
    send(pack_word(OP_BUILD, 11'd0, 11'd0, 11'd0));
    random_words(MAXN, 40, 1'b1);

    // Small trees, rebuilt now and then among the queries.
    for (int ph = 0; ph < 2; ph++) begin
      small_n = int'($urandom_range(2, 32));
      write_count(11'(small_n));
      load_tree(small_n, ph);
      send(pack_word(OP_BUILD, 11'd0, 11'd0, 11'd0));
      random_words(small_n, 40, 1'b1);
    end

    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (fail_count == 0) $display("tree_lca_binary_lifting_reroot_tb passed");
    else $display("tree_lca_binary_lifting_reroot_tb failed");
    $finish;
  end

endmodule
